// ===== src/djac_pkg.sv =====
package djac_pkg;

   localparam int MAX_POINTS = 256;
   localparam int MASS_BITS  = 16;
   localparam int FRAC_BITS  = 16;
   localparam int SIM_W      = 20;

   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int CNT_W  = IDX_W + 1;
   localparam int KEY_W  = MASS_BITS + FRAC_BITS;
   localparam int ENT_W  = KEY_W + 2 * MASS_BITS;
   localparam int SUM_W  = MASS_BITS + IDX_W;
   localparam int PROD_W = SUM_W + MASS_BITS;
   localparam int DEN_W  = PROD_W + 1;
   localparam int DVD_W  = 2 * MASS_BITS + FRAC_BITS;
   localparam int STEP_W = $clog2(DVD_W + 1);

   localparam logic [SIM_W-1:0] SIM_MAX = {SIM_W{1'b1}};

endpackage

// ===== src/djac_ram.sv =====
module djac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/djac_div.sv =====
module djac_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [djac_pkg::DVD_W-1:0]    dividend,
   input  logic [djac_pkg::DEN_W-1:0]    divisor,
   output logic                          done,
   output logic [djac_pkg::DVD_W-1:0]    quotient
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [djac_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [djac_pkg::DVD_W-1:0]    dvd_ff, dvd_in;
   logic [djac_pkg::DEN_W-1:0]    rem_ff, rem_in;
   logic [djac_pkg::DEN_W-1:0]    dsr_ff, dsr_in;
   logic [djac_pkg::DEN_W:0]      trial;
   logic                          fits;

   // restoring division, one quotient bit per cycle; quotient shifts in behind the dividend
   assign trial = {rem_ff, dvd_ff[djac_pkg::DVD_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[djac_pkg::DVD_W-2:0], fits};
         rem_in = fits ? djac_pkg::DEN_W'(trial - {1'b0, dsr_ff})
                       : trial[djac_pkg::DEN_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == djac_pkg::STEP_W'(djac_pkg::DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// ===== src/discrete_probability_jaccard.sv =====
// Probability Jaccard similarity of two discrete distributions.
// req channel: one pair of unsigned Q0.16 masses per transaction, req_last on
// the final pair of a set. rsp channel: one transaction per set, carrying the
// Q4.16 similarity (saturated) and a flag for pairs dropped beyond capacity.
// For each pair a rank key is found by the shared bit-serial divider, then
// the pair is inserted into the rank-ordered pair memory, after every stored
// pair with a larger key has been moved up one place.
// After the last pair and a setup state, the set is walked once in rank
// order: per pair a read, a load and a step on, plus three passes through
// the one multiplier and a division where both masses are nonzero; then
// the output state. The divider and the pair memory (one read, one write
// port) set the pace. req_ready is high only while the block waits for a pair.
// A finished result sits in the output register; while the receiver stalls
// the block still takes pairs of the next set, and holds the next result
// back until the register is free.
// Reset empties the set; the memory is not cleared and needs no pass.
module discrete_probability_jaccard (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [djac_pkg::MASS_BITS-1:0]    req_mass_a,
   input  logic [djac_pkg::MASS_BITS-1:0]    req_mass_b,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [djac_pkg::SIM_W-1:0]        rsp_similarity,
   output logic                              rsp_overflow
);

   typedef enum logic [3:0] {
      IDLE, KEY, INS_RD, INS_CMP, INS_PUT, SETUP, RD, LOAD,
      MUL1, MUL2, MUL3, DSTART, DIV, NEXT, OUT
   } state_type;

   state_type                       state_ff, state_in;
   logic [djac_pkg::CNT_W-1:0]      count_ff, count_in;
   logic                            flag_ff, flag_in;
   logic [djac_pkg::SUM_W-1:0]      suma_ff, suma_in;
   logic [djac_pkg::MASS_BITS-1:0]  a_ff, a_in;
   logic [djac_pkg::MASS_BITS-1:0]  b_ff, b_in;
   logic                            last_ff, last_in;
   logic [djac_pkg::KEY_W-1:0]      key_ff, key_in;
   logic [djac_pkg::CNT_W-1:0]      j_ff, j_in;
   logic [djac_pkg::SUM_W-1:0]      sa_ff, sa_in;
   logic [djac_pkg::SUM_W-1:0]      sb_ff, sb_in;
   logic [djac_pkg::PROD_W-1:0]     num_ff, num_in;
   logic [djac_pkg::DEN_W-1:0]      den_ff, den_in;
   logic [djac_pkg::SIM_W-1:0]      acc_ff, acc_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [djac_pkg::SIM_W-1:0]      rsp_sim_ff, rsp_sim_in;
   logic                            rsp_ovf_ff, rsp_ovf_in;

   logic                            wr_en;
   logic [djac_pkg::IDX_W-1:0]      wr_addr;
   logic [djac_pkg::ENT_W-1:0]      wr_data;
   logic [djac_pkg::IDX_W-1:0]      rd_addr;
   logic [djac_pkg::ENT_W-1:0]      rd_data;
   logic [djac_pkg::MASS_BITS-1:0]  rd_a;
   logic [djac_pkg::MASS_BITS-1:0]  rd_b;

   logic                            div_start;
   logic [djac_pkg::DVD_W-1:0]      div_dividend;
   logic [djac_pkg::DEN_W-1:0]      div_divisor;
   logic                            div_done;
   logic [djac_pkg::DVD_W-1:0]      div_quot;

   logic [djac_pkg::SUM_W-1:0]      mul_x;
   logic [djac_pkg::MASS_BITS-1:0]  mul_y;
   logic [djac_pkg::PROD_W-1:0]     prod;
   logic [djac_pkg::SIM_W:0]        acc_sum;
   logic                            req_fire;
   logic                            room;

   // entries are {key, a, b}, kept in ascending key order
   djac_ram #(.WIDTH(djac_pkg::ENT_W), .DEPTH(djac_pkg::MAX_POINTS)) u_pairs (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   djac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_ready = (state_ff == IDLE);
   assign req_fire  = req_valid && req_ready;
   assign room      = count_ff < djac_pkg::CNT_W'(djac_pkg::MAX_POINTS);

   assign rd_a = rd_data[2*djac_pkg::MASS_BITS-1:djac_pkg::MASS_BITS];
   assign rd_b = rd_data[djac_pkg::MASS_BITS-1:0];

   assign prod    = djac_pkg::PROD_W'(mul_x) * djac_pkg::PROD_W'(mul_y);
   assign acc_sum = {1'b0, acc_ff} + (djac_pkg::SIM_W + 1)'(div_quot[djac_pkg::FRAC_BITS:0]);

   always_comb begin
      unique case (state_ff)
         MUL2:    begin mul_x = sa_ff; mul_y = b_ff; end
         MUL3:    begin mul_x = sb_ff; mul_y = a_ff; end
         default: begin mul_x = djac_pkg::SUM_W'(a_ff); mul_y = b_ff; end
      endcase
   end

   always_comb begin
      div_start    = 1'b0;
      div_dividend = djac_pkg::DVD_W'({req_mass_a, djac_pkg::FRAC_BITS'(0)});
      div_divisor  = djac_pkg::DEN_W'(req_mass_b) + 1'b1;
      if (state_ff == DSTART) begin
         div_start    = 1'b1;
         div_dividend = {num_ff[2*djac_pkg::MASS_BITS-1:0], djac_pkg::FRAC_BITS'(0)};
         div_divisor  = den_ff;
      end else if (req_fire && room) begin
         div_start = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      flag_in      = flag_ff;
      suma_in      = suma_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      last_in      = last_ff;
      key_in       = key_ff;
      j_in         = j_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_sim_in   = rsp_sim_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = j_ff[djac_pkg::IDX_W-1:0];
      wr_data      = {key_ff, a_ff, b_ff};
      rd_addr      = j_ff[djac_pkg::IDX_W-1:0];

      unique case (state_ff)
         IDLE: begin
            if (req_fire) begin
               a_in    = req_mass_a;
               b_in    = req_mass_b;
               last_in = req_last;
               if (room) begin
                  suma_in  = suma_ff + djac_pkg::SUM_W'(req_mass_a);
                  state_in = KEY;
               end else begin
                  flag_in = 1'b1;
                  if (req_last) begin
                     state_in = SETUP;
                  end
               end
            end
         end
         KEY: begin
            if (div_done) begin
               key_in   = div_quot[djac_pkg::KEY_W-1:0];
               j_in     = count_ff;
               state_in = (count_ff == '0) ? INS_PUT : INS_RD;
            end
         end
         INS_RD: begin
            rd_addr  = djac_pkg::IDX_W'(j_ff - 1'b1);
            state_in = INS_CMP;
         end
         INS_CMP: begin
            // strict compare keeps equal keys in arrival order
            if (rd_data[djac_pkg::ENT_W-1 -: djac_pkg::KEY_W] > key_ff) begin
               wr_en    = 1'b1;
               wr_data  = rd_data;
               j_in     = j_ff - 1'b1;
               state_in = (j_ff == djac_pkg::CNT_W'(1)) ? INS_PUT : INS_RD;
            end else begin
               state_in = INS_PUT;
            end
         end
         INS_PUT: begin
            wr_en    = 1'b1;
            count_in = count_ff + 1'b1;
            state_in = last_ff ? SETUP : IDLE;
         end
         SETUP: begin
            sa_in    = suma_ff;
            sb_in    = '0;
            acc_in   = '0;
            j_in     = '0;
            state_in = RD;
         end
         RD: begin
            state_in = LOAD;
         end
         LOAD: begin
            a_in  = rd_a;
            b_in  = rd_b;
            sa_in = sa_ff - djac_pkg::SUM_W'(rd_a);
            sb_in = sb_ff + djac_pkg::SUM_W'(rd_b);
            state_in = (rd_a != '0 && rd_b != '0) ? MUL1 : NEXT;
         end
         MUL1: begin
            num_in   = prod;
            state_in = MUL2;
         end
         MUL2: begin
            den_in   = djac_pkg::DEN_W'(prod);
            state_in = MUL3;
         end
         MUL3: begin
            den_in   = den_ff + djac_pkg::DEN_W'(prod);
            state_in = DSTART;
         end
         DSTART: begin
            state_in = DIV;
         end
         DIV: begin
            if (div_done) begin
               acc_in   = acc_sum[djac_pkg::SIM_W] ? djac_pkg::SIM_MAX
                                                   : acc_sum[djac_pkg::SIM_W-1:0];
               state_in = NEXT;
            end
         end
         NEXT: begin
            j_in     = j_ff + 1'b1;
            state_in = (j_ff + 1'b1 == count_ff) ? OUT : RD;
         end
         OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_sim_in   = acc_ff;
               rsp_ovf_in   = flag_ff;
               count_in     = '0;
               flag_in      = 1'b0;
               suma_in      = '0;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         flag_ff      <= 1'b0;
         suma_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         flag_ff      <= flag_in;
         suma_ff      <= suma_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff       <= a_in;
      b_ff       <= b_in;
      last_ff    <= last_in;
      key_ff     <= key_in;
      j_ff       <= j_in;
      sa_ff      <= sa_in;
      sb_ff      <= sb_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      acc_ff     <= acc_in;
      rsp_sim_ff <= rsp_sim_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_similarity = rsp_sim_ff;
   assign rsp_overflow   = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= djac_pkg::CNT_W'(djac_pkg::MAX_POINTS))
      else $error("pair count beyond capacity");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == OUT))
      else $error("result raised outside the output state");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == KEY || state_ff == DIV))
      else $error("divider finished while nobody waits");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == INS_PUT) |-> (count_ff < djac_pkg::CNT_W'(djac_pkg::MAX_POINTS)))
      else $error("insert into a full pair memory");
`endif

endmodule

// ===== bench/tb_discrete_probability_jaccard.sv =====
module tb_discrete_probability_jaccard;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [djac_pkg::MASS_BITS-1:0] mass_a;
      logic [djac_pkg::MASS_BITS-1:0] mass_b;
      logic                           last;
   } pair_type;

   typedef struct {
      logic [djac_pkg::SIM_W-1:0] similarity;
      logic                       overflow;
   } jaccard_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [djac_pkg::MASS_BITS-1:0] req_mass_a;
   logic [djac_pkg::MASS_BITS-1:0] req_mass_b;
   logic                           req_last;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [djac_pkg::SIM_W-1:0]     rsp_similarity;
   logic                           rsp_overflow;

   discrete_probability_jaccard dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_mass_a(req_mass_a), .req_mass_b(req_mass_b), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_similarity(rsp_similarity), .rsp_overflow(rsp_overflow)
   );

   pair_type    pending_pairs[$];
   jaccard_type expected_sims[$];
   int          failures = 0;
   int          pairs_taken = 0;
   int          pairs_queued = 0;

   // predictor copy of the set under collection
   longint unsigned held_a [djac_pkg::MAX_POINTS];
   longint unsigned held_b [djac_pkg::MAX_POINTS];
   int              held_count = 0;
   bit              held_dropped = 0;

   function automatic logic [djac_pkg::SIM_W-1:0] set_similarity(int n);
      int              order [djac_pkg::MAX_POINTS];
      longint unsigned rank [djac_pkg::MAX_POINTS];
      longint unsigned sa, sb, acc, a, b, den, k;
      int              j, p;
      sa = 0;
      sb = 0;
      acc = 0;
      for (int i = 0; i < n; i++) begin
         rank[i] = (held_a[i] << djac_pkg::FRAC_BITS) / (held_b[i] + 64'd1);
         sa += held_a[i];
      end
      // stable insertion by key, ties keep arrival order
      for (int i = 0; i < n; i++) begin
         k = rank[i];
         j = i;
         while (j > 0 && rank[order[j-1]] > k) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = i;
      end
      for (int i = 0; i < n; i++) begin
         p = order[i];
         a = held_a[p];
         b = held_b[p];
         sa -= a;
         sb += b;
         if (a != 0 && b != 0) begin
            den = sa * b + a * sb;
            acc += ((a * b) << djac_pkg::FRAC_BITS) / den;
            if (acc > 64'(djac_pkg::SIM_MAX)) acc = 64'(djac_pkg::SIM_MAX);
         end
      end
      return acc[djac_pkg::SIM_W-1:0];
   endfunction

   function automatic void predict_pair(pair_type p);
      jaccard_type r;
      if (held_count < djac_pkg::MAX_POINTS) begin
         held_a[held_count] = 64'(p.mass_a);
         held_b[held_count] = 64'(p.mass_b);
         held_count++;
      end else begin
         held_dropped = 1'b1;
      end
      if (p.last) begin
         r.similarity = set_similarity(held_count);
         r.overflow = held_dropped;
         expected_sims.insert(expected_sims.size(), r);
         held_count = 0;
         held_dropped = 1'b0;
      end
   endfunction

   function automatic void queue_pair(int a, int b, bit last);
      pair_type p;
      p.mass_a = djac_pkg::MASS_BITS'(a);
      p.mass_b = djac_pkg::MASS_BITS'(b);
      p.last = last;
      pending_pairs.insert(pending_pairs.size(), p);
      pairs_queued++;
   endfunction

   function automatic int pick_mass();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return 0;
      if (r < 14) return 16'hffff;
      if (r < 20) return $urandom_range(1, 15);
      return $urandom_range(0, 16'hffff);
   endfunction

   function automatic void queue_set(int n);
      for (int i = 0; i < n; i++)
         queue_pair(pick_mass(), pick_mass(), i == n - 1);
   endfunction

   function automatic int pick_gap(int n);
      int r;
      if ((n / 150) % 3 == 0) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // driver
   bit       req_took = 0;
   int       req_gap = 0;
   pair_type cur;

   always @(posedge clock) req_took <= req_valid && req_ready;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_mass_a <= '0;
         req_mass_b <= '0;
         req_last <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_pairs.size() > 0) begin
            cur = pending_pairs.pop_front();
            req_mass_a <= cur.mass_a;
            req_mass_b <= cur.mass_b;
            req_last <= cur.last;
            req_valid <= 1'b1;
            req_gap = pick_gap(pairs_taken);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off
   int  hold_left = 0;
   bit  hold_done = 0;
   int  rsp_gap = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!hold_done && pairs_taken >= 400) begin
            hold_done = 1'b1;
            hold_left = 4000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_gap = pick_gap(pairs_taken + 75);
         end
      end
   end

   // monitor
   jaccard_type want;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_pair(pair_type'{req_mass_a, req_mass_b, req_last});
            pairs_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_sims.size() == 0) begin
               $display("%0t: unexpected transaction sim=%0d ovf=%0d", $time,
                        rsp_similarity, rsp_overflow);
               failures++;
            end else begin
               want = expected_sims.pop_front();
               if (rsp_similarity !== want.similarity) begin
                  $display("%0t: similarity expected %0d actual %0d", $time,
                           want.similarity, rsp_similarity);
                  failures++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $display("%0t: overflow expected %0d actual %0d", $time,
                           want.overflow, rsp_overflow);
                  failures++;
               end
            end
         end
      end
   end

   initial begin
      #60ms;
      $display("tb_discrete_probability_jaccard failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      // single pairs at the extremes
      queue_pair(16'hffff, 16'hffff, 1);
      queue_pair(0, 0, 1);
      queue_pair(0, 16'hffff, 1);
      queue_pair(16'hffff, 0, 1);
      queue_pair(1, 1, 1);
      // zero masses mixed in, still counted in the sums
      queue_pair(0, 500, 0);
      queue_pair(700, 0, 0);
      queue_pair(1000, 2000, 1);
      // equal keys keep arrival order
      queue_pair(100, 199, 0);
      queue_pair(200, 399, 0);
      queue_pair(300, 599, 1);
      // identical distributions
      queue_pair(16384, 16384, 0);
      queue_pair(16384, 16384, 0);
      queue_pair(32768, 32768, 1);
      // reversed key order and many tiny terms
      queue_pair(16'hffff, 1, 0);
      queue_pair(1, 16'hffff, 0);
      queue_pair(16'h8000, 16'h7fff, 0);
      queue_pair(16'h7fff, 16'h8000, 1);
      // beyond capacity, last pair dropped too
      queue_set(djac_pkg::MAX_POINTS + 3);
      queue_set(djac_pkg::MAX_POINTS);
      while (pairs_queued < 1100) begin
         if ($urandom_range(0, 49) == 0) queue_set($urandom_range(30, 60));
         else queue_set($urandom_range(1, 12));
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      while (pending_pairs.size() > 0 || req_valid || expected_sims.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      if (failures == 0 && expected_sims.size() == 0)
         $display("tb_discrete_probability_jaccard passed");
      else
         $display("tb_discrete_probability_jaccard failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/djac_pkg.sv
src/djac_ram.sv
src/djac_div.sv
src/discrete_probability_jaccard.sv
bench/tb_discrete_probability_jaccard.sv
